FILE: hw/rtl/wsg_pkg.sv
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// wave sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int MAX_POINTS_DEF  = 512;
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int SINE_Q          = SINE_TABLE_SIZE / 4;
  localparam int SINE_P          = 4 * SINE_Q;
  localparam int MIDSCALE        = 2047;
  localparam int CODE_TOP        = 4095;
  localparam int SINE_DEN        = 32768;
  localparam int DUTY_FULL       = 100;
  localparam int RECIP_100       = 671089;
  localparam int RECIP_W         = 20;
  localparam int RECIP_SH        = 26;

  localparam int SI_W   = 9;
  localparam int CODE_W = 12;
  localparam int CFG_W  = 14;
  localparam int IDX_W  = 3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_RAMP   = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_DC     = 2'd3
  } wave_kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WAVE_KIND   = 3'd0,
    REG_POINT_COUNT = 3'd1,
    REG_AMPLITUDE   = 3'd2,
    REG_OFFSET      = 3'd3,
    REG_DUTY        = 3'd4
  } cfg_index_t;

  typedef logic [14:0] sine_rom_t [SINE_Q+1];

  // Sine of a quarter-wave point in unsigned Q0.15 by a Taylor series in Q2.30.
  function automatic logic [14:0] quarter_sine(input longint unsigned k);
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    u    = (k << 30) / SINE_Q;
    x    = (u * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        default: term = term / 156;
      endcase
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) begin
      sum = 32767;
    end
    return sum[14:0];
  endfunction

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t t;
    for (int k = 0; k <= SINE_Q; k++) begin
      t[k] = quarter_sine(longint'(k));
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/wave_sample_generator_unit.sv
// ----------------------------------------------------------------------------
// wave_sample_generator_unit
// Turns a sample index into the 12-bit DAC code of one point of a sine,
// ramp or triangle, or square period, or a DC level, clamped to 0..4095 with a clip flag.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the output is not stalled. The
// pipeline holds three dividers with one quotient bit per stage: the index
// modulo the point count, the sine phase, and the final level division.
// A stall on the output holds the whole pipeline. After a write, configuration
// settles into the derived split points through the registers nu_r, nm1_r and
// the products, d_ramp_r and d_sq_r, and then span_r.
module wave_sample_generator_unit
  import wsg_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SI_W-1:0]   in_sample_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_dac_code,
  output logic              out_clipped,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int NU_W   = $clog2(MAX_POINTS + 1);
  localparam int CW     = (NU_W > 10) ? NU_W : 10;
  localparam int PROD_W = NU_W + 7;
  localparam int Q100_W = PROD_W + RECIP_W;
  localparam int D_W    = NU_W + 1;
  localparam int SW     = ((NU_W > SI_W) ? NU_W : SI_W) + 3;
  localparam int PW     = $clog2(SINE_P + 1);
  localparam int BD_W   = NU_W + PW;
  localparam int PH_W   = $clog2(SINE_P);
  localparam int AW     = $clog2(SINE_Q + 1);
  localparam int M1A_W  = (SW + 1 > 17) ? SW + 1 : 17;
  localparam int M2A_W  = 17;
  localparam int M2B_W  = (SW > 17) ? SW : 17;
  localparam int P1_W   = M1A_W + CFG_W;
  localparam int P2_W   = M2A_W + M2B_W;
  localparam int NUM_W  = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DEN_W  = (NU_W + 2 > 16) ? NU_W + 2 : 16;

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  // Configuration registers.
  wave_kind_t               wave_kind_r;
  logic [9:0]               point_count_r;
  logic signed [CFG_W-1:0]  amplitude_r;
  logic signed [CFG_W-1:0]  offset_r;
  logic [6:0]               duty_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_kind_r   <= WAVE_SINE;
      point_count_r <= 10'd40;
      amplitude_r   <= '0;
      offset_r      <= '0;
      duty_r        <= 7'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        REG_WAVE_KIND:   wave_kind_r   <= wave_kind_t'(cfg_data[1:0]);
        REG_POINT_COUNT: point_count_r <= cfg_data[9:0];
        REG_AMPLITUDE:   amplitude_r   <= cfg_data;
        REG_OFFSET:      offset_r      <= cfg_data;
        REG_DUTY:        duty_r        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Values derived from the configuration, which settle through a chain of registers after a write.
  logic [CW-1:0]           pc_ext;
  logic [NU_W-1:0]         nu_r;
  logic [6:0]              dutyc_r;
  logic signed [NU_W:0]    nm1_r;
  logic [PROD_W-1:0]       prod_ramp_r;
  logic [PROD_W-1:0]       prod_sq_r;
  logic [Q100_W-1:0]       q100_ramp;
  logic [Q100_W-1:0]       q100_sq;
  logic [D_W-1:0]          d_ramp_r;
  logic [D_W-1:0]          d_sq_r;
  logic signed [SW-1:0]    span_r;

  assign pc_ext    = CW'(point_count_r);
  assign q100_ramp = Q100_W'(prod_ramp_r) * Q100_W'(RECIP_100);
  assign q100_sq   = Q100_W'(prod_sq_r) * Q100_W'(RECIP_100);

  always_ff @(posedge clk) begin
    nu_r        <= (pc_ext > CW'(MAX_POINTS)) ? NU_W'(MAX_POINTS) : NU_W'(pc_ext);
    dutyc_r     <= (duty_r > 7'(DUTY_FULL)) ? 7'(DUTY_FULL) : duty_r;
    nm1_r       <= $signed({1'b0, nu_r}) - (NU_W + 1)'(1);
    prod_ramp_r <= PROD_W'(nu_r) * PROD_W'(dutyc_r);
    prod_sq_r   <= PROD_W'(nu_r) * PROD_W'(duty_r);
    d_ramp_r    <= D_W'(q100_ramp >> RECIP_SH);
    d_sq_r      <= D_W'(q100_sq >> RECIP_SH);
    span_r      <= SW'(nm1_r) - SW'(d_ramp_r);
  end

  // Pipeline control: everything moves together unless the output is held.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic            s1_v_r;
  logic [SI_W-1:0] s1_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_i_r <= in_sample_index;
    end
  end

  // Index modulo the point count.
  logic            ma_v;
  logic [SI_W-1:0] ma_sb;
  logic [NU_W-1:0] ma_rem;

  wsg_div_pipe #(
    .DVD_W (SI_W),
    .DSR_W (NU_W),
    .SB_W  (SI_W)
  ) u_div_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s1_v_r),
    .in_dvd   (s1_i_r),
    .in_dsr   (nu_r),
    .in_sb    (s1_i_r),
    .out_v    (ma_v),
    .out_quot (),
    .out_rem  (ma_rem),
    .out_sb   (ma_sb)
  );

  // Phase within the full sine period.
  logic            ph_v;
  logic [SI_W-1:0] ph_sb;
  logic [BD_W-1:0] ph_quot;
  logic [BD_W-1:0] ph_dvd;

  assign ph_dvd = BD_W'(ma_rem) * BD_W'(SINE_P);

  wsg_div_pipe #(
    .DVD_W (BD_W),
    .DSR_W (NU_W),
    .SB_W  (SI_W)
  ) u_div_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (ma_v),
    .in_dvd   (ph_dvd),
    .in_dsr   (nu_r),
    .in_sb    (ma_sb),
    .out_v    (ph_v),
    .out_quot (ph_quot),
    .out_rem  (),
    .out_sb   (ph_sb)
  );

  // Quadrant fold onto the quarter-wave table.
  logic [PH_W-1:0] phase;
  logic [1:0]      quad;
  logic [PH_W-1:0] qr;
  logic            qd_v_r;
  logic            qd_neg_r;
  logic [AW-1:0]   qd_addr_r;
  logic [SI_W-1:0] qd_i_r;

  assign phase = (nu_r == '0) ? '0 : ph_quot[PH_W-1:0];

  always_comb begin
    if (phase >= PH_W'(3 * SINE_Q)) begin
      quad = 2'd3;
      qr   = phase - PH_W'(3 * SINE_Q);
    end else if (phase >= PH_W'(2 * SINE_Q)) begin
      quad = 2'd2;
      qr   = phase - PH_W'(2 * SINE_Q);
    end else if (phase >= PH_W'(SINE_Q)) begin
      quad = 2'd1;
      qr   = phase - PH_W'(SINE_Q);
    end else begin
      quad = 2'd0;
      qr   = phase;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_v_r <= 1'b0;
    end else if (en) begin
      qd_v_r <= ph_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qd_neg_r  <= quad[1];
      qd_addr_r <= quad[0] ? AW'(PH_W'(SINE_Q) - qr) : AW'(qr);
      qd_i_r    <= ph_sb;
    end
  end

  // Table read.
  logic            rm_v_r;
  logic            rm_neg_r;
  logic [14:0]     rm_sine_r;
  logic [SI_W-1:0] rm_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_v_r <= 1'b0;
    end else if (en) begin
      rm_v_r <= qd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_sine_r <= SINE_ROM[qd_addr_r];
      rm_neg_r  <= qd_neg_r;
      rm_i_r    <= qd_i_r;
    end
  end

  // Numerator terms and denominator for each waveform.
  logic signed [SW-1:0]    i_s;
  logic signed [SW-1:0]    nm1_s;
  logic signed [SW-1:0]    d_s;
  logic signed [SW-1:0]    dq_s;
  logic signed [SW-1:0]    pos;
  logic signed [SW-1:0]    xd;
  logic                    ramp_ok;
  logic signed [M1A_W-1:0] sine_s;
  logic signed [M2A_W-1:0] base;
  logic signed [M2A_W-1:0] low2;
  logic signed [M2A_W-1:0] high2;
  logic signed [M1A_W-1:0] m1a;
  logic signed [M2A_W-1:0] m2a;
  logic signed [M2B_W-1:0] m2b;
  logic [DEN_W-1:0]        den;

  assign i_s    = SW'(rm_i_r);
  assign nm1_s  = SW'(nm1_r);
  assign d_s    = SW'(d_ramp_r);
  assign dq_s   = SW'(d_sq_r);
  assign sine_s = rm_neg_r ? -M1A_W'(rm_sine_r) : M1A_W'(rm_sine_r);
  assign base   = M2A_W'(MIDSCALE) + M2A_W'(offset_r);
  assign low2   = (base <<< 1) - M2A_W'(amplitude_r);
  assign high2  = (base <<< 1) + M2A_W'(amplitude_r);

  always_comb begin
    pos     = '0;
    xd      = '0;
    ramp_ok = 1'b0;
    if (dutyc_r == 7'd0 || dutyc_r == 7'(DUTY_FULL)) begin
      if (nm1_s > 0) begin
        ramp_ok = 1'b1;
        xd      = nm1_s;
        pos     = (dutyc_r == 7'd0) ? nm1_s - i_s : i_s;
      end
    end else if (i_s <= d_s) begin
      if (d_s > 0) begin
        ramp_ok = 1'b1;
        xd      = d_s;
        pos     = i_s;
      end
    end else if (span_r > 0) begin
      ramp_ok = 1'b1;
      xd      = span_r;
      pos     = nm1_s - i_s;
    end
  end

  always_comb begin
    case (wave_kind_r)
      WAVE_SINE: begin
        m1a = sine_s;
        m2a = base;
        m2b = M2B_W'(SINE_DEN);
        den = DEN_W'(SINE_DEN);
      end
      WAVE_RAMP: begin
        if (ramp_ok) begin
          m1a = M1A_W'(pos) <<< 1;
          m2a = low2;
          m2b = M2B_W'(xd);
          den = DEN_W'(xd) << 1;
        end else begin
          m1a = '0;
          m2a = low2;
          m2b = M2B_W'(1);
          den = DEN_W'(2);
        end
      end
      WAVE_SQUARE: begin
        m1a = '0;
        m2a = (i_s <= dq_s) ? high2 : low2;
        m2b = M2B_W'(1);
        den = DEN_W'(2);
      end
      default: begin
        m1a = '0;
        m2a = base;
        m2b = M2B_W'(1);
        den = DEN_W'(1);
      end
    endcase
  end

  logic                   mu_v_r;
  logic signed [P1_W-1:0] mu_p1_r;
  logic signed [P2_W-1:0] mu_p2_r;
  logic [DEN_W-1:0]       mu_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_v_r <= 1'b0;
    end else if (en) begin
      mu_v_r <= rm_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_p1_r  <= P1_W'(m1a) * P1_W'(amplitude_r);
      mu_p2_r  <= P2_W'(m2a) * P2_W'(m2b);
      mu_den_r <= den;
    end
  end

  logic                    sm_v_r;
  logic signed [NUM_W-1:0] sm_num_r;
  logic [DEN_W-1:0]        sm_den_r;
  logic                    sm_neg;
  logic [NUM_W-1:0]        sm_abs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_v_r <= 1'b0;
    end else if (en) begin
      sm_v_r <= mu_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_num_r <= NUM_W'(mu_p1_r) + NUM_W'(mu_p2_r);
      sm_den_r <= mu_den_r;
    end
  end

  assign sm_neg = sm_num_r[NUM_W-1];
  assign sm_abs = sm_neg ? -sm_num_r : sm_num_r;

  // Level division, truncated toward zero.
  logic             dv_v;
  logic             dv_neg;
  logic [MAG_W-1:0] dv_quot;

  wsg_div_pipe #(
    .DVD_W (MAG_W),
    .DSR_W (DEN_W),
    .SB_W  (1)
  ) u_div_level (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sm_v_r),
    .in_dvd   (sm_abs[MAG_W-1:0]),
    .in_dsr   (sm_den_r),
    .in_sb    (sm_neg),
    .out_v    (dv_v),
    .out_quot (dv_quot),
    .out_rem  (),
    .out_sb   (dv_neg)
  );

  // Clamp and output register.
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_clip_r;
  logic [CODE_W-1:0] code_nxt;
  logic              clip_nxt;

  always_comb begin
    if (dv_neg && dv_quot != '0) begin
      code_nxt = '0;
      clip_nxt = 1'b1;
    end else if (dv_quot > MAG_W'(CODE_TOP)) begin
      code_nxt = CODE_W'(CODE_TOP);
      clip_nxt = 1'b1;
    end else begin
      code_nxt = dv_quot[CODE_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_code_r <= code_nxt;
      out_clip_r <= clip_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dac_code = out_code_r;
  assign out_clipped  = out_clip_r;

endmodule

FILE: hw/rtl/wsg_div_pipe.sv
// ----------------------------------------------------------------------------
// wsg_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside each item.
// ----------------------------------------------------------------------------
module wsg_div_pipe #(
  parameter int DVD_W = 8,
  parameter int DSR_W = 8,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [DVD_W-1:0] in_dvd,
  input  logic [DSR_W-1:0] in_dsr,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_v,
  output logic [DVD_W-1:0] out_quot,
  output logic [DSR_W-1:0] out_rem,
  output logic [SB_W-1:0]  out_sb
);

  logic             v_r   [DVD_W];
  logic [DVD_W-1:0] w_r   [DVD_W];
  logic [DSR_W-1:0] rem_r [DVD_W];
  logic [DSR_W-1:0] dsr_r [DVD_W];
  logic [SB_W-1:0]  sb_r  [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic             pv;
    logic [DVD_W-1:0] pw;
    logic [DSR_W-1:0] prem;
    logic [DSR_W-1:0] pdsr;
    logic [SB_W-1:0]  psb;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign pv   = in_v;
      assign pw   = in_dvd;
      assign prem = '0;
      assign pdsr = in_dsr;
      assign psb  = in_sb;
    end else begin : g_next
      assign pv   = v_r[k-1];
      assign pw   = w_r[k-1];
      assign prem = rem_r[k-1];
      assign pdsr = dsr_r[k-1];
      assign psb  = sb_r[k-1];
    end

    assign trial = {prem, pw[DVD_W-1]};
    assign ge    = trial >= {1'b0, pdsr};
    assign diff  = trial - {1'b0, pdsr};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r[k]   <= {pw[DVD_W-2:0], ge};
        rem_r[k] <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        dsr_r[k] <= pdsr;
        sb_r[k]  <= psb;
      end
    end
  end

  assign out_v    = v_r[DVD_W-1];
  assign out_quot = w_r[DVD_W-1];
  assign out_rem  = rem_r[DVD_W-1];
  assign out_sb   = sb_r[DVD_W-1];

endmodule
